@@ rtl/alps_pkg.sv @@
`default_nettype none

package alps_pkg;

  // Image and coordinate geometry
  localparam int unsigned IMAGE_DIM = 4096;
  localparam int COORD_W = 12;
  localparam int ROI_W = 13;
  localparam logic [ROI_W-1:0] ROI_EMPTY_MIN = ROI_W'(IMAGE_DIM);
  localparam logic [ROI_W-1:0] ROI_EMPTY_MAX = '1;

  // Shading constants, distances in Q9 (two per Q8 step)
  localparam int CULL_MARGIN = 1536;
  localparam int EXCESS_CLAMP = 1024;
  localparam int EXCESS_SHIFT = $clog2(2 * EXCESS_CLAMP);
  localparam int GREY_SNAP = 225;

  // Distance pipeline
  localparam int DIST_W = 16;
  localparam int ROOT_STEPS = DIST_W;

  // Queue between classifier and datapath
  localparam int FIFO_DEPTH = 2;

  // Q32 helpers for the sigmoid table
  localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
  localparam logic [63:0] Q32_MAX = 64'hFFFF_FFFF;

  typedef enum logic [3:0] {
    REG_START_X      = 4'd0,
    REG_START_Y      = 4'd1,
    REG_END_X        = 4'd2,
    REG_END_Y        = 4'd3,
    REG_LINE_WIDTH   = 4'd4,
    REG_ERASE        = 4'd5,
    REG_IMAGE_WIDTH  = 4'd6,
    REG_IMAGE_HEIGHT = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [20:0] sx;
    logic signed [20:0] sy;
    logic signed [20:0] ex;
    logic signed [20:0] ey;
    logic [15:0]        lw;
    logic               erase;
    logic [12:0]        iw;
    logic [12:0]        ih;
  } cfg_t;

  typedef struct packed {
    logic               live;
    logic               op;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [7:0]         old;
  } item_t;

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 32;
  endfunction

  // exp(-s) in Q32 for 0 <= s <= 6 in Q32
  function automatic logic [63:0] exp_neg_q32(logic [63:0] s);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x4;
    logic [63:0] e;
    x  = s >> 6;
    x2 = qmul(x, x);
    x3 = qmul(x2, x);
    x4 = qmul(x3, x);
    e  = Q32_ONE - x + x2 / 2 - x3 / 6 + x4 / 24;
    if (e > Q32_MAX) begin
      e = Q32_MAX;
    end
    for (int k = 0; k < 6; k++) begin
      e = qmul(e, e);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ rtl/alps_if.sv @@
`default_nettype none

interface alps_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  old_value;
  modport source (output valid, op, pixel_x, pixel_y, old_value, input ready);
  modport sink (input valid, op, pixel_x, pixel_y, old_value, output ready);
endinterface

interface alps_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         new_value;
  logic               write_enable;
  logic [12:0]        roi_xmin;
  logic [12:0]        roi_ymin;
  logic signed [12:0] roi_xmax;
  logic signed [12:0] roi_ymax;
  modport source (output valid, new_value, write_enable, roi_xmin, roi_ymin, roi_xmax,
                  roi_ymax, input ready);
  modport sink (input valid, new_value, write_enable, roi_xmin, roi_ymin, roi_xmax,
                roi_ymax, output ready);
endinterface

interface alps_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/alps_front.sv @@
`default_nettype none

module alps_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  alps_cfg_if.sink        cfg_i,
  alps_in_if.sink         in_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output alps_pkg::item_t item_o,
  output alps_pkg::cfg_t  conf_o
);
  import alps_pkg::*;

  cfg_t cfg_q;

  logic signed [20:0] mnx, mxx, mny, mxy;
  logic signed [22:0] lw_s, lo_x, hi_x, lo_y, hi_y, ix, iy;
  logic               in_img, in_box, immut;

  assign cfg_i.ready = 1'b1;
  assign conf_o = cfg_q;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sx    <= '0;
      cfg_q.sy    <= '0;
      cfg_q.ex    <= '0;
      cfg_q.ey    <= '0;
      cfg_q.lw    <= 16'd768;
      cfg_q.erase <= 1'b0;
      cfg_q.iw    <= 13'd4096;
      cfg_q.ih    <= 13'd4096;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_START_X:      cfg_q.sx    <= cfg_i.data[20:0];
        REG_START_Y:      cfg_q.sy    <= cfg_i.data[20:0];
        REG_END_X:        cfg_q.ex    <= cfg_i.data[20:0];
        REG_END_Y:        cfg_q.ey    <= cfg_i.data[20:0];
        REG_LINE_WIDTH:   cfg_q.lw    <= cfg_i.data[15:0];
        REG_ERASE:        cfg_q.erase <= cfg_i.data[0];
        REG_IMAGE_WIDTH:  cfg_q.iw    <= cfg_i.data[12:0];
        REG_IMAGE_HEIGHT: cfg_q.ih    <= cfg_i.data[12:0];
        default: ;
      endcase
    end
  end

  // Widened bounding box in whole pixels
  always_comb begin
    mnx  = (cfg_q.sx < cfg_q.ex) ? cfg_q.sx : cfg_q.ex;
    mxx  = (cfg_q.sx > cfg_q.ex) ? cfg_q.sx : cfg_q.ex;
    mny  = (cfg_q.sy < cfg_q.ey) ? cfg_q.sy : cfg_q.ey;
    mxy  = (cfg_q.sy > cfg_q.ey) ? cfg_q.sy : cfg_q.ey;
    lw_s = $signed({7'd0, cfg_q.lw});
    lo_x = (23'(mnx) - lw_s) >>> 8;
    lo_y = (23'(mny) - lw_s) >>> 8;
    hi_x = (23'(mxx) + lw_s + 23'sd255) >>> 8;
    hi_y = (23'(mxy) + lw_s + 23'sd255) >>> 8;
    ix   = $signed({11'd0, in_i.pixel_x});
    iy   = $signed({11'd0, in_i.pixel_y});
  end

  // Classify the pixel
  assign in_img = ({1'b0, in_i.pixel_x} < cfg_q.iw) && ({1'b0, in_i.pixel_y} < cfg_q.ih);
  assign in_box = (ix >= lo_x) && (ix < hi_x) && (iy >= lo_y) && (iy < hi_y);
  assign immut  = in_i.old_value == (cfg_q.erase ? 8'h00 : 8'hFF);

  assign item_o.live = !in_i.op && in_img && in_box && !immut;
  assign item_o.op   = in_i.op;
  assign item_o.px   = in_i.pixel_x;
  assign item_o.py   = in_i.pixel_y;
  assign item_o.old  = in_i.old_value;

  assign in_i.ready = !fifo_full_i;
  assign push_o     = in_i.valid && !fifo_full_i;

endmodule

`default_nettype wire

@@ rtl/alps_fifo.sv @@
`default_nettype none

module alps_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  alps_pkg::item_t item_i,
  input  logic            pop_i,
  output alps_pkg::item_t item_o,
  output logic            empty_o,
  output logic            full_o
);
  import alps_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CNT_W'(FIFO_DEPTH);
  assign item_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/alps_dist.sv @@
`default_nettype none

module alps_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  alps_pkg::item_t               item_i,
  input  alps_pkg::cfg_t                conf_i,
  output logic                          valid_o,
  output alps_pkg::item_t               item_o,
  output logic [alps_pkg::DIST_W-1:0]   dist_o
);
  import alps_pkg::*;

  localparam int NW = 90;
  localparam int PW = 60;
  localparam int MW = 44;

  // Stage 1: offsets and products
  logic signed [22:0] wx, wy, ux, uy;
  logic signed [21:0] vx, vy;
  logic signed [45:0] vxwx_q, vywy_q, vxwy_q, vywx_q, vxvx_q, vyvy_q;
  logic signed [45:0] wxwx_q, wywy_q, uxux_q, uyuy_q;
  item_t              it1_q;
  logic               v1_q;

  assign wx = $signed({3'd0, item_i.px, 8'd0}) - 23'(conf_i.sx);
  assign wy = $signed({3'd0, item_i.py, 8'd0}) - 23'(conf_i.sy);
  assign ux = $signed({3'd0, item_i.px, 8'd0}) - 23'(conf_i.ex);
  assign uy = $signed({3'd0, item_i.py, 8'd0}) - 23'(conf_i.ey);
  assign vx = 22'(conf_i.ex) - 22'(conf_i.sx);
  assign vy = 22'(conf_i.ey) - 22'(conf_i.sy);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vxwx_q <= 46'(vx * wx);
      vywy_q <= 46'(vy * wy);
      vxwy_q <= 46'(vx * wy);
      vywx_q <= 46'(vy * wx);
      vxvx_q <= 46'(vx * vx);
      vyvy_q <= 46'(vy * vy);
      wxwx_q <= 46'(wx * wx);
      wywy_q <= 46'(wy * wy);
      uxux_q <= 46'(ux * ux);
      uyuy_q <= 46'(uy * uy);
      it1_q  <= item_i;
    end
  end

  // Stage 2: dot, length, cross and squared point distances
  logic signed [46:0] dot2_q, len2_q, cr2_q, ns2_q, ne2_q;
  item_t              it2_q;
  logic               v2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dot2_q <= 47'(vxwx_q) + 47'(vywy_q);
      len2_q <= 47'(vxvx_q) + 47'(vyvy_q);
      cr2_q  <= 47'(vxwy_q) - 47'(vywx_q);
      ns2_q  <= 47'(wxwx_q) + 47'(wywy_q);
      ne2_q  <= 47'(uxux_q) + 47'(uyuy_q);
      it2_q  <= it1_q;
    end
  end

  // Stage 3: pick start point, end point or line
  logic          line3_q;
  logic [MW-1:0] m3_q, npt3_q, acr3_q;
  item_t         it3_q;
  logic          v3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acr3_q <= cr2_q[46] ? 44'(-cr2_q) : 44'(cr2_q);
      it3_q  <= it2_q;
      if (dot2_q[46] || dot2_q == 47'sd0) begin
        line3_q <= 1'b0;
        npt3_q  <= 44'(ns2_q);
        m3_q    <= MW'(1);
      end else if (dot2_q >= len2_q) begin
        line3_q <= 1'b0;
        npt3_q  <= 44'(ne2_q);
        m3_q    <= MW'(1);
      end else begin
        line3_q <= 1'b1;
        npt3_q  <= 44'(ns2_q);
        m3_q    <= 44'(len2_q);
      end
    end
  end

  // Stage 4: partial products of the squared cross
  logic [63:0]   ll4_q;
  logic [43:0]   lh4_q;
  logic [23:0]   hh4_q;
  logic          line4_q;
  logic [MW-1:0] m4_q, npt4_q;
  item_t         it4_q;
  logic          v4_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ll4_q   <= 64'(acr3_q[31:0] * acr3_q[31:0]);
      lh4_q   <= 44'(acr3_q[31:0] * acr3_q[43:32]);
      hh4_q   <= 24'(acr3_q[43:32] * acr3_q[43:32]);
      line4_q <= line3_q;
      m4_q    <= m3_q;
      npt4_q  <= npt3_q;
      it4_q   <= it3_q;
    end
  end

  // Stage 5 feeds the root pipeline: remainder, running d*m, digits
  logic [NW-1:0]     r_q  [ROOT_STEPS+1];
  logic [PW-1:0]     p_q  [ROOT_STEPS+1];
  logic [DIST_W-1:0] d_q  [ROOT_STEPS+1];
  logic [MW-1:0]     m_q  [ROOT_STEPS+1];
  item_t             it_q [ROOT_STEPS+1];
  logic              v_q  [ROOT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q[0]  <= line4_q ? NW'(ll4_q) + (NW'(lh4_q) << 33) + (NW'(hh4_q) << 64)
                         : NW'(npt4_q);
      p_q[0]  <= '0;
      d_q[0]  <= '0;
      m_q[0]  <= m4_q;
      it_q[0] <= it4_q;
    end
  end

  // Valid chain through the fixed stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v_q[0] <= v4_q;
    end
  end

  // One result bit per stage: largest d with d*d*m <= n
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam int B = ROOT_STEPS - 1 - k;
    logic [NW-1:0] trial;
    logic          take;

    assign trial = (NW'(p_q[k]) << (B + 1)) + (NW'(m_q[k]) << (2 * B));
    assign take  = trial <= r_q[k];

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[k+1]  <= take ? r_q[k] - trial : r_q[k];
        p_q[k+1]  <= take ? p_q[k] + (PW'(m_q[k]) << B) : p_q[k];
        d_q[k+1]  <= take ? d_q[k] | (DIST_W'(1) << B) : d_q[k];
        m_q[k+1]  <= m_q[k];
        it_q[k+1] <= it_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  assign valid_o = v_q[ROOT_STEPS];
  assign item_o  = it_q[ROOT_STEPS];
  assign dist_o  = d_q[ROOT_STEPS];

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(dist_o) && $stable(valid_o))
    else $error("distance pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/alps_shade.sv @@
`default_nettype none

module alps_shade #(
  parameter int SIGMOID_LUT_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  alps_pkg::cfg_t              conf_i,
  input  logic                        valid_i,
  input  alps_pkg::item_t             item_i,
  input  logic [alps_pkg::DIST_W-1:0] dist_i,
  alps_out_if.source                  out_o,
  output logic                        adv_o
);
  import alps_pkg::*;

  localparam int IDX_W = $clog2(SIGMOID_LUT_DEPTH);
  localparam int PROD_W = IDX_W + EXCESS_SHIFT + 1;

  // Sigmoid grey table, built at elaboration
  logic [7:0] lut [SIGMOID_LUT_DEPTH];

  for (genvar i = 0; i < SIGMOID_LUT_DEPTH; i++) begin : g_lut
    localparam logic [63:0] Den  = 64'(SIGMOID_LUT_DEPTH - 1);
    localparam logic [63:0] Mid  = 64'd6 * Den;
    localparam logic [63:0] Pos  = 64'd12 * 64'(i);
    localparam logic [63:0] Diff = (Pos >= Mid) ? Pos - Mid : Mid - Pos;
    localparam logic [63:0] S    = (Diff << 32) / Den;
    localparam logic [63:0] E    = exp_neg_q32(S);
    localparam logic [63:0] G    = (Pos >= Mid) ? (64'd255 * E) / (Q32_ONE + E)
                                                : (64'd255 * Q32_ONE) / (Q32_ONE + E);
    assign lut[i] = (G >= 64'(GREY_SNAP)) ? 8'd255 : G[7:0];
  end

  logic oval_q;
  assign adv_o = !oval_q || out_o.ready;

  // Stage 1: cull and clamped excess
  logic               cull;
  logic signed [17:0] ex;
  logic [16:0]        lim;
  logic [11:0]        pos;
  logic [11:0]        pos1_q;
  logic               keep1_q, v1_q;
  item_t              it1_q;

  always_comb begin
    lim  = 17'(conf_i.lw) + 17'(CULL_MARGIN);
    cull = {dist_i, 1'b0} > lim;
    ex   = $signed({1'b0, dist_i, 1'b0}) - $signed({2'b00, conf_i.lw});
    if (ex > 18'(EXCESS_CLAMP)) begin
      pos = 12'(2 * EXCESS_CLAMP);
    end else if (ex < -18'(EXCESS_CLAMP)) begin
      pos = '0;
    end else begin
      pos = 12'(ex + 18'(EXCESS_CLAMP));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pos1_q  <= pos;
      keep1_q <= item_i.live && !cull;
      it1_q   <= item_i;
    end
  end

  // Stage 2: table index, rounded
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx2_q;
  logic              keep2_q, v2_q;
  item_t             it2_q;

  assign prod = PROD_W'(pos1_q) * PROD_W'(SIGMOID_LUT_DEPTH - 1) + PROD_W'(EXCESS_CLAMP);

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      idx2_q  <= prod[EXCESS_SHIFT +: IDX_W];
      keep2_q <= keep1_q;
      it2_q   <= it1_q;
    end
  end

  // Stage 3: blend with the old value and grow the region, or clear it for an op item
  logic [7:0]              grey, cand, nv;
  logic                    we;
  logic [ROI_W-1:0]        xmin_q, ymin_q, xmin_d, ymin_d;
  logic signed [ROI_W-1:0] xmax_q, ymax_q, xmax_d, ymax_d;
  logic [7:0]              nv_q;
  logic                    we_q;

  always_comb begin
    grey = lut[idx2_q];
    cand = 8'd255 - grey;
    if (conf_i.erase) begin
      nv   = (cand < it2_q.old) ? cand : it2_q.old;
    end else begin
      nv   = (grey > it2_q.old) ? grey : it2_q.old;
    end
    if (!keep2_q) begin
      nv = it2_q.old;
    end
    we     = keep2_q && (nv != it2_q.old);
    xmin_d = xmin_q;
    ymin_d = ymin_q;
    xmax_d = xmax_q;
    ymax_d = ymax_q;
    if (it2_q.op) begin
      xmin_d = ROI_EMPTY_MIN;
      ymin_d = ROI_EMPTY_MIN;
      xmax_d = ROI_EMPTY_MAX;
      ymax_d = ROI_EMPTY_MAX;
    end else if (we) begin
      if ({1'b0, it2_q.px} < xmin_q) xmin_d = {1'b0, it2_q.px};
      if ({1'b0, it2_q.py} < ymin_q) ymin_d = {1'b0, it2_q.py};
      if ($signed({1'b0, it2_q.px}) > xmax_q) xmax_d = $signed({1'b0, it2_q.px});
      if ($signed({1'b0, it2_q.py}) > ymax_q) ymax_d = $signed({1'b0, it2_q.py});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      nv_q <= nv;
      we_q <= we;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= ROI_EMPTY_MIN;
      ymin_q <= ROI_EMPTY_MIN;
      xmax_q <= ROI_EMPTY_MAX;
      ymax_q <= ROI_EMPTY_MAX;
    end else if (adv_o && v2_q) begin
      xmin_q <= xmin_d;
      ymin_q <= ymin_d;
      xmax_q <= xmax_d;
      ymax_q <= ymax_d;
    end
  end

  // Valid chain and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      oval_q <= 1'b0;
    end else if (adv_o) begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      oval_q <= v2_q;
    end
  end

  assign out_o.valid        = oval_q;
  assign out_o.new_value    = nv_q;
  assign out_o.write_enable = we_q;
  assign out_o.roi_xmin     = xmin_q;
  assign out_o.roi_ymin     = ymin_q;
  assign out_o.roi_xmax     = xmax_q;
  assign out_o.roi_ymax     = ymax_q;

`ifndef SYNTH
  a_region_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xmin_q == ROI_EMPTY_MIN) == (xmax_q == ROI_EMPTY_MAX))
    else $error("region bounds disagree on emptiness");
  a_we_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && we_q) |-> (xmin_q != ROI_EMPTY_MIN) && (ymin_q != ROI_EMPTY_MIN))
    else $error("write without region");
  a_region_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && !out_o.ready) |=> $stable(xmin_q) && $stable(xmax_q) && $stable(ymin_q))
    else $error("region changed while result stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/antialiased_line_pixel_shader.sv @@
`default_nettype none

// Antialiased thick-line pixel shader. One pixel transaction (coordinate plus
// old value) enters per clock and one result leaves per clock in the same
// order; a sustained rate of one pixel per cycle holds as long as the output
// side keeps taking results. An accepted pixel is written into the two-entry
// input queue and leaves that queue when the pipeline advances, then passes
// five stages for the vector products and case select, sixteen for the
// distance square root (one result bit per stage), and three for the
// sigmoid lookup, blend and region update. The input stays ready while the
// queue has room, so a stalled output does not block the input until the
// queue fills. Configuration writes are taken every cycle and must be issued
// only while no pixel is in flight.
module antialiased_line_pixel_shader #(
  parameter int SIGMOID_LUT_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alps_cfg_if.sink    cfg_i,
  alps_in_if.sink     in_i,
  alps_out_if.source  out_o
);
  import alps_pkg::*;

  cfg_t              conf;
  item_t             f_item, q_item, d_item;
  logic              push, full, empty, adv, pop, d_valid;
  logic [DIST_W-1:0] dist_val;

  assign pop = adv && !empty;

  alps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .in_i        (in_i),
    .fifo_full_i (full),
    .push_o      (push),
    .item_o      (f_item),
    .conf_o      (conf)
  );

  alps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .empty_o (empty),
    .full_o  (full)
  );

  alps_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (!empty),
    .item_i  (q_item),
    .conf_i  (conf),
    .valid_o (d_valid),
    .item_o  (d_item),
    .dist_o  (dist_val)
  );

  alps_shade #(
    .SIGMOID_LUT_DEPTH (SIGMOID_LUT_DEPTH)
  ) u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .conf_i  (conf),
    .valid_i (d_valid),
    .item_i  (d_item),
    .dist_i  (dist_val),
    .out_o   (out_o),
    .adv_o   (adv)
  );

endmodule

`default_nettype wire
